FILE: rtl/bwpc_pkg.sv
// ----------------------------------------------------------------------------
// Beacon WPA-PSK classifier package
// Shared constants, verdict codes and the result word for the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bwpc_pkg;

   // Frame length limit default, in bytes
   localparam int MAX_FRAME_DEFAULT = 2048;

   // Header layout (byte offsets from frame control)
   localparam int HDR_LEN     = 24;
   localparam int IE_START    = 36;
   localparam int ADDR3_FIRST = 16;
   localparam int ADDR3_LAST  = 21;
   localparam int CAP_LOW     = 34;

   // Frame control byte: management beacon pattern under mask
   localparam logic [7:0] FC_TYPE_MASK = 8'hFC;
   localparam logic [7:0] FC_BEACON    = 8'h80;

   // Element ids
   localparam logic [7:0] ID_SSID   = 8'd0;
   localparam logic [7:0] ID_RSN    = 8'd48;
   localparam logic [7:0] ID_VENDOR = 8'd221;

   // WPA vendor element OUI and type, and RSN version 1 as it sits on the wire
   localparam logic [31:0] WPA_VENDOR_TAG = 32'h0050F201;
   localparam logic [15:0] RSN_VERSION1   = 16'h0100;

   // Suite selector reset values
   localparam logic [31:0] RSN_PSK_RESET = 32'h000FAC02;
   localparam logic [31:0] WPA_PSK_RESET = 32'h0050F202;

   // Configuration register indexes
   localparam logic CSR_RSN_PSK = 1'b0;
   localparam logic CSR_WPA_PSK = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_SHORT      = 3'd0,
      VERDICT_NOT_BEACON = 3'd1,
      VERDICT_MALFORMED  = 3'd2,
      VERDICT_NO_PRIVACY = 3'd3,
      VERDICT_NO_PSK     = 3'd4,
      VERDICT_WPA_PSK    = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0]  ssid_length;
      logic [47:0] bssid;
      verdict_type verdict;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/beacon_wpa_psk_classifier_core.sv
// ----------------------------------------------------------------------------
// Beacon WPA-PSK classifier core
// Classifies one 802.11 frame per run of bytes and reports its BSSID and
// first SSID length.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries the frame one byte per word, frame control first; tlast
//          marks the final byte. One verdict word leaves on rsp_* per frame.
//   csr_*  writes the RSN and WPA PSK suite selectors; write only between
//          frames, with no verdict pending.
// Throughput: one byte per cycle, sustained across frame boundaries, while
//   no verdict waits in the result register on rsp_tready. The walk state
//   is updated by one pass of logic per byte. Verdict: valid on rsp_* from
//   the result register in the cycle after the last byte is accepted.
// Stall: while a verdict waits in the result register req_tready stays high
//   only in cycles where rsp_tready takes it, so the result register never
//   overflows and no byte is lost.
// Reset: clears the walk state and the result valid flag, and loads the
//   suite selectors with their standard PSK values.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_wpa_psk_classifier_core #(
   parameter int MAX_FRAME = bwpc_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Frame bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  wire logic        req_tlast,   // frame_end
   // Verdicts
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [2:0] verdict, [50:3] bssid,
                                         // [58:51] ssid_length, rest zero
   // Configuration writes
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic                 take;
   bwpc_pkg::result_type result;
   bwpc_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsn_suite_ff;
   logic [31:0]          wpa_suite_ff;

   // Accept a byte unless a held verdict is not being taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   bwpc_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .frame_byte (req_tdata),
      .frame_end  (req_tlast),
      .rsn_suite  (rsn_suite_ff),
      .wpa_suite  (wpa_suite_ff),
      .result     (result)
   );

   // Suite selector registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsn_suite_ff <= bwpc_pkg::RSN_PSK_RESET;
         wpa_suite_ff <= bwpc_pkg::WPA_PSK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bwpc_pkg::CSR_RSN_PSK: rsn_suite_ff <= csr_wdata;
            bwpc_pkg::CSR_WPA_PSK: wpa_suite_ff <= csr_wdata;
            default: rsn_suite_ff <= rsn_suite_ff;
         endcase
      end
   end

   // Result register: load on the last byte, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.ssid_length, rsp_data_ff.bssid,
                        rsp_data_ff.verdict};

endmodule

`default_nettype wire

FILE: rtl/bwpc_parser.sv
// ----------------------------------------------------------------------------
// Beacon WPA-PSK classifier: frame parser
// Holds the per-frame walk state and updates it once per accepted byte.
// Gives the verdict for the frame on the byte marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module bwpc_parser #(
   parameter int MAX_FRAME = bwpc_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [7:0]           frame_byte,
   input  wire logic                 frame_end,
   input  wire logic [31:0]          rsn_suite,
   input  wire logic [31:0]          wpa_suite,
   output bwpc_pkg::result_type      result
);

   localparam int PosW = $clog2(MAX_FRAME + 1);

   typedef enum logic [1:0] {
      PH_ID   = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic {
      EV_ACTIVE = 1'b0,
      EV_IGNORE = 1'b1
   } ev_type;

   // State registers and next values
   logic [PosW-1:0] pos_ff, pos_in;
   logic            kind_ok_ff, kind_ok_in;
   logic [47:0]     addr3_ff, addr3_in;
   logic            priv_ff, priv_in;
   phase_type       phase_ff, phase_in;
   logic [7:0]      elem_id_ff, elem_id_in;
   logic [7:0]      left_ff, left_in;
   logic [7:0]      offset_ff, offset_in;
   logic [15:0]     cipher_ff, cipher_in;
   logic [15:0]     akm_ff, akm_in;
   logic [31:0]     window_ff, window_in;
   ev_type          ev_ff, ev_in;
   logic            ssid_seen_ff, ssid_seen_in;
   logic [7:0]      ssid_len_ff, ssid_len_in;
   logic            psk_ff, psk_in;
   logic            bad_ff, bad_in;

   // Body decode helpers
   logic            is_rsn;
   logic [7:0]      total;
   logic [7:0]      rsn_off;
   logic [7:0]      rsn_len;
   logic [31:0]     window_shift;
   logic [31:0]     psk_suite;
   logic [15:0]     cipher_new;
   logic [15:0]     akm_new;
   logic [18:0]     akm_pos;
   logic [19:0]     cipher_need;
   logic [19:0]     akm_need;
   logic [7:0]      suite_k;
   logic [8:0]      suite_k_next;
   logic [7:0]      left_dec;
   logic            walking;
   logic            cut_short;

   assign is_rsn       = (elem_id_ff == bwpc_pkg::ID_RSN);
   assign total        = offset_ff + left_ff;
   assign rsn_off      = is_rsn ? offset_ff : offset_ff - 8'd4;
   assign rsn_len      = is_rsn ? total : total - 8'd4;
   assign window_shift = {window_ff[23:0], frame_byte};
   assign psk_suite    = is_rsn ? rsn_suite : wpa_suite;
   assign cipher_new   = {frame_byte, cipher_ff[7:0]};
   assign akm_new      = {frame_byte, akm_ff[7:0]};
   assign akm_pos      = 19'd8 + {1'b0, cipher_ff, 2'b00};
   assign cipher_need  = 20'd10 + {2'b00, cipher_new, 2'b00};
   assign akm_need     = {1'b0, akm_pos} + 20'd2 + {2'b00, akm_new, 2'b00};
   assign suite_k      = rsn_off - akm_pos[7:0] - 8'd2;
   assign suite_k_next = {1'b0, suite_k} + 9'd1;
   assign left_dec     = left_ff - 8'd1;
   assign walking      = (pos_ff >= PosW'(bwpc_pkg::IE_START)) && kind_ok_ff && priv_ff;

   // Next state for one byte
   always_comb begin
      pos_in       = pos_ff;
      kind_ok_in   = kind_ok_ff;
      addr3_in     = addr3_ff;
      priv_in      = priv_ff;
      phase_in     = phase_ff;
      elem_id_in   = elem_id_ff;
      left_in      = left_ff;
      offset_in    = offset_ff;
      cipher_in    = cipher_ff;
      akm_in       = akm_ff;
      window_in    = window_ff;
      ev_in        = ev_ff;
      ssid_seen_in = ssid_seen_ff;
      ssid_len_in  = ssid_len_ff;
      psk_in       = psk_ff;
      bad_in       = bad_ff;

      if (pos_ff >= PosW'(MAX_FRAME)) begin
         // Drop bytes past the length limit and mark the frame malformed
         bad_in = 1'b1;
      end else begin
         pos_in = pos_ff + PosW'(1);
         if (pos_ff == '0) begin
            kind_ok_in = ((frame_byte & bwpc_pkg::FC_TYPE_MASK) == bwpc_pkg::FC_BEACON);
         end
         if (pos_ff >= PosW'(bwpc_pkg::ADDR3_FIRST) &&
             pos_ff <= PosW'(bwpc_pkg::ADDR3_LAST)) begin
            addr3_in = {addr3_ff[39:0], frame_byte};
         end
         if (pos_ff == PosW'(bwpc_pkg::CAP_LOW)) begin
            priv_in = frame_byte[4];
         end

         if (walking) begin
            case (phase_ff)
               PH_ID: begin
                  elem_id_in = frame_byte;
                  phase_in   = PH_LEN;
               end
               PH_LEN: begin
                  // Element header: arm checks for the element kinds of interest
                  left_in   = frame_byte;
                  offset_in = 8'd0;
                  window_in = 32'd0;
                  cipher_in = 16'd0;
                  akm_in    = 16'd0;
                  ev_in     = EV_IGNORE;
                  if (elem_id_ff == bwpc_pkg::ID_SSID) begin
                     if (!ssid_seen_ff) begin
                        ssid_seen_in = 1'b1;
                        ssid_len_in  = 8'd0;
                        ev_in        = EV_ACTIVE;
                     end
                  end else if (elem_id_ff == bwpc_pkg::ID_RSN) begin
                     if (frame_byte >= 8'd2) ev_in = EV_ACTIVE;
                  end else if (elem_id_ff == bwpc_pkg::ID_VENDOR) begin
                     if (frame_byte >= 8'd6) ev_in = EV_ACTIVE;
                  end
                  phase_in = (frame_byte == 8'd0) ? PH_ID : PH_BODY;
               end
               default: begin
                  // Element body
                  if (ev_ff == EV_ACTIVE) begin
                     if (elem_id_ff == bwpc_pkg::ID_SSID) begin
                        if (frame_byte != 8'd0) ssid_len_in = total;
                        ev_in = EV_IGNORE;
                     end else if (!is_rsn && offset_ff < 8'd4) begin
                        // Vendor OUI and type
                        window_in = window_shift;
                        if (offset_ff == 8'd3 &&
                            window_shift != bwpc_pkg::WPA_VENDOR_TAG) begin
                           ev_in = EV_IGNORE;
                        end
                     end else begin
                        // RSN-format body
                        window_in = window_shift;
                        if (rsn_off == 8'd1) begin
                           if (window_shift[15:0] != bwpc_pkg::RSN_VERSION1) begin
                              ev_in = EV_IGNORE;
                           end else if (rsn_len < 8'd8) begin
                              bad_in = 1'b1;
                              ev_in  = EV_IGNORE;
                           end
                        end else if (rsn_off == 8'd6) begin
                           cipher_in = {8'd0, frame_byte};
                        end else if (rsn_off == 8'd7) begin
                           cipher_in = cipher_new;
                           if ({12'd0, rsn_len} < cipher_need) begin
                              bad_in = 1'b1;
                              ev_in  = EV_IGNORE;
                           end
                        end else if (rsn_off < 8'd8) begin
                           ev_in = ev_ff;
                        end else if ({11'd0, rsn_off} < akm_pos) begin
                           ev_in = ev_ff;
                        end else if ({11'd0, rsn_off} == akm_pos) begin
                           akm_in = {8'd0, frame_byte};
                        end else if ({11'd0, rsn_off} == akm_pos + 19'd1) begin
                           akm_in = akm_new;
                           if ({12'd0, rsn_len} < akm_need) begin
                              bad_in = 1'b1;
                              ev_in  = EV_IGNORE;
                           end else if (akm_new == 16'd0) begin
                              ev_in = EV_IGNORE;
                           end
                        end else if (suite_k[1:0] == 2'b11) begin
                           // Last byte of one AKM suite
                           if (window_shift == psk_suite) psk_in = 1'b1;
                           if ({9'd0, suite_k_next} >= {akm_ff, 2'b00}) ev_in = EV_IGNORE;
                        end
                     end
                  end
                  offset_in = offset_ff + 8'd1;
                  left_in   = left_dec;
                  if (left_dec == 8'd0) phase_in = PH_ID;
               end
            endcase
         end
      end
   end

   // Verdict from the state after this byte
   assign cut_short = (phase_in == PH_BODY) && (offset_in != 8'd0);

   always_comb begin
      result.bssid       = addr3_in;
      result.ssid_length = 8'd0;
      if (pos_in < PosW'(bwpc_pkg::HDR_LEN)) begin
         result.verdict = bwpc_pkg::VERDICT_SHORT;
         result.bssid   = 48'd0;
      end else if (bad_in || cut_short) begin
         result.verdict = bwpc_pkg::VERDICT_MALFORMED;
      end else if (!kind_ok_in) begin
         result.verdict = bwpc_pkg::VERDICT_NOT_BEACON;
      end else if (pos_in < PosW'(bwpc_pkg::IE_START)) begin
         result.verdict = bwpc_pkg::VERDICT_MALFORMED;
      end else if (!priv_in) begin
         result.verdict = bwpc_pkg::VERDICT_NO_PRIVACY;
      end else if (psk_in) begin
         result.verdict = bwpc_pkg::VERDICT_WPA_PSK;
      end else begin
         result.verdict = bwpc_pkg::VERDICT_NO_PSK;
      end
      if (result.verdict == bwpc_pkg::VERDICT_MALFORMED ||
          result.verdict == bwpc_pkg::VERDICT_NO_PSK ||
          result.verdict == bwpc_pkg::VERDICT_WPA_PSK) begin
         result.ssid_length = ssid_len_in;
      end
   end

   // Hold walk state; clear it after each verdict
   always_ff @(posedge clock) begin
      if (reset || (take && frame_end)) begin
         pos_ff       <= '0;
         kind_ok_ff   <= 1'b0;
         addr3_ff     <= 48'd0;
         priv_ff      <= 1'b0;
         phase_ff     <= PH_ID;
         elem_id_ff   <= 8'd0;
         left_ff      <= 8'd0;
         offset_ff    <= 8'd0;
         cipher_ff    <= 16'd0;
         akm_ff       <= 16'd0;
         window_ff    <= 32'd0;
         ev_ff        <= EV_ACTIVE;
         ssid_seen_ff <= 1'b0;
         ssid_len_ff  <= 8'd0;
         psk_ff       <= 1'b0;
         bad_ff       <= 1'b0;
      end else if (take) begin
         pos_ff       <= pos_in;
         kind_ok_ff   <= kind_ok_in;
         addr3_ff     <= addr3_in;
         priv_ff      <= priv_in;
         phase_ff     <= phase_in;
         elem_id_ff   <= elem_id_in;
         left_ff      <= left_in;
         offset_ff    <= offset_in;
         cipher_ff    <= cipher_in;
         akm_ff       <= akm_in;
         window_ff    <= window_in;
         ev_ff        <= ev_in;
         ssid_seen_ff <= ssid_seen_in;
         ssid_len_ff  <= ssid_len_in;
         psk_ff       <= psk_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Beacon WPA-PSK classifier testbench
// Streams 802.11 frames into the classifier one byte per word and checks each
// verdict word against a cycle-free model of the element walk. Directed
// frames come first, then random frames, mostly beacons with random element
// content, under several PSK suite settings and several idle and stall patterns.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT  = 500_000;
   localparam int         MAX_FRAME    = bwpc_pkg::MAX_FRAME_DEFAULT;
   localparam logic [7:0] PRIVACY_MASK = 8'h10;
   localparam logic [7:0] FC_DATA      = 8'h08;
   localparam logic [7:0] ID_FILLER    = 8'd7;

   typedef enum logic [1:0] {IE_AT_ID, IE_AT_LEN, IE_AT_BODY} ie_phase_type;

   // Ways to damage a suite element
   typedef enum int {
      FLAW_NONE, FLAW_VERSION, FLAW_SHORT_BODY, FLAW_CIPHER_COUNT, FLAW_AKM_COUNT,
      FLAW_OUI
   } ie_flaw_type;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } frame_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] frame_byte
   logic        req_tlast = 1'b0;    // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [2:0] verdict, [50:3] bssid, [58:51] ssid_length
   logic        csr_we = 1'b0;
   logic        csr_index = bwpc_pkg::CSR_RSN_PSK;
   logic [31:0] csr_wdata = 32'h0;

   beacon_wpa_psk_classifier_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frame_word_type       pending_bytes[$];
   bwpc_pkg::result_type expected_verdicts[$];
   logic [7:0]           frame_buf[$];
   frame_word_type       next_word;
   bwpc_pkg::result_type want;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   // Suite selectors as last written
   logic [31:0] rsn_suite;
   logic [31:0] wpa_suite;

   // Walk state of the frame in progress
   logic [11:0]  walk_pos;
   logic         kind_ok;
   logic [47:0]  addr3;
   logic         privacy;
   ie_phase_type ie_phase;
   logic [7:0]   ie_kind;
   logic [7:0]   ie_left;
   logic [7:0]   ie_offset;
   logic [15:0]  n_cipher;
   logic [15:0]  n_akm;
   logic [31:0]  suite_win;
   logic         ie_skip;
   logic         ssid_seen;
   logic [7:0]   ssid_len;
   logic         psk_hit;
   logic         frame_bad;

   // ---------------------------------------------------------------- model

   function automatic void clear_walk();
      walk_pos  = '0;
      kind_ok   = 1'b0;
      addr3     = '0;
      privacy   = 1'b0;
      ie_phase  = IE_AT_ID;
      ie_kind   = '0;
      ie_left   = '0;
      ie_offset = '0;
      n_cipher  = '0;
      n_akm     = '0;
      suite_win = '0;
      ie_skip   = 1'b0;
      ssid_seen = 1'b0;
      ssid_len  = '0;
      psk_hit   = 1'b0;
      frame_bad = 1'b0;
   endfunction

   function automatic void fail_ie();
      frame_bad = 1'b1;
      ie_skip   = 1'b1;
   endfunction

   // One byte of an RSN-format body at offset o, body length len
   function automatic void suite_byte(int unsigned o, int unsigned len, logic [7:0] b,
                                      bit is_rsn);
      int unsigned akm_at;
      int unsigned k;
      suite_win = {suite_win[23:0], b};
      if (o == 1) begin
         if (suite_win[15:0] != bwpc_pkg::RSN_VERSION1) begin
            ie_skip = 1'b1;
            return;
         end
         if (len < 8) fail_ie();
         return;
      end
      if (o == 6) begin
         n_cipher = {8'h00, b};
         return;
      end
      if (o == 7) begin
         n_cipher[15:8] = b;
         if (len < 10 + 4 * 32'(n_cipher)) fail_ie();
         return;
      end
      if (o < 8) return;
      akm_at = 8 + 4 * 32'(n_cipher);
      if (o < akm_at) return;
      if (o == akm_at) begin
         n_akm = {8'h00, b};
         return;
      end
      if (o == akm_at + 1) begin
         n_akm[15:8] = b;
         if (len < akm_at + 2 + 4 * 32'(n_akm)) fail_ie();
         else if (n_akm == 0) ie_skip = 1'b1;
         return;
      end
      // last byte of each AKM suite: compare the whole selector
      k = o - (akm_at + 2);
      if (k[1:0] == 2'b11) begin
         if (suite_win == (is_rsn ? rsn_suite : wpa_suite)) psk_hit = 1'b1;
         if (k + 1 >= 4 * 32'(n_akm)) ie_skip = 1'b1;
      end
   endfunction

   function automatic void ie_header(logic [7:0] len);
      ie_left   = len;
      ie_offset = '0;
      suite_win = '0;
      n_cipher  = '0;
      n_akm     = '0;
      ie_skip   = 1'b1;
      if (ie_kind == bwpc_pkg::ID_SSID) begin
         if (!ssid_seen) begin
            ssid_seen = 1'b1;
            ssid_len  = '0;
            ie_skip   = 1'b0;
         end
      end else if (ie_kind == bwpc_pkg::ID_RSN) begin
         if (len >= 2) ie_skip = 1'b0;
      end else if (ie_kind == bwpc_pkg::ID_VENDOR) begin
         if (len >= 6) ie_skip = 1'b0;
      end
      ie_phase = (len == 0) ? IE_AT_ID : IE_AT_BODY;
   endfunction

   function automatic void ie_body(logic [7:0] b);
      int unsigned off;
      int unsigned total;
      off   = 32'(ie_offset);
      total = 32'(ie_offset) + 32'(ie_left);
      if (!ie_skip) begin
         if (ie_kind == bwpc_pkg::ID_SSID) begin
            if (b != 0) ssid_len = total[7:0];
            ie_skip = 1'b1;
         end else if (ie_kind == bwpc_pkg::ID_RSN) begin
            suite_byte(off, total, b, 1'b1);
         end else if (off < 4) begin
            suite_win = {suite_win[23:0], b};
            if (off == 3 && suite_win != bwpc_pkg::WPA_VENDOR_TAG) ie_skip = 1'b1;
         end else begin
            suite_byte(off - 4, total - 4, b, 1'b0);
         end
      end
      ie_offset = ie_offset + 8'd1;
      ie_left   = ie_left - 8'd1;
      if (ie_left == 0) ie_phase = IE_AT_ID;
   endfunction

   // Advance the walk by one accepted byte; on the last byte queue the verdict
   function automatic void classify_byte(logic [7:0] b, logic last);
      logic [11:0]          pos;
      bwpc_pkg::result_type verdict_out;
      pos = walk_pos;
      if (pos >= MAX_FRAME) begin
         frame_bad = 1'b1;
      end else begin
         walk_pos = pos + 12'd1;
         if (pos == 0) kind_ok = ((b & bwpc_pkg::FC_TYPE_MASK) == bwpc_pkg::FC_BEACON);
         if (pos >= bwpc_pkg::ADDR3_FIRST && pos <= bwpc_pkg::ADDR3_LAST)
            addr3 = {addr3[39:0], b};
         if (pos == bwpc_pkg::CAP_LOW) privacy = ((b & PRIVACY_MASK) != 0);
         if (pos >= bwpc_pkg::IE_START && kind_ok && privacy) begin
            case (ie_phase)
               IE_AT_ID: begin
                  ie_kind  = b;
                  ie_phase = IE_AT_LEN;
               end
               IE_AT_LEN: ie_header(b);
               default:   ie_body(b);
            endcase
         end
      end
      if (!last) return;

      // a frame ending inside an element body is malformed
      if (ie_phase == IE_AT_BODY && ie_offset > 0) frame_bad = 1'b1;
      verdict_out.bssid       = addr3;
      verdict_out.ssid_length = '0;
      if (walk_pos < bwpc_pkg::HDR_LEN) begin
         verdict_out.verdict = bwpc_pkg::VERDICT_SHORT;
         verdict_out.bssid   = '0;
      end else if (frame_bad) verdict_out.verdict = bwpc_pkg::VERDICT_MALFORMED;
      else if (!kind_ok)      verdict_out.verdict = bwpc_pkg::VERDICT_NOT_BEACON;
      else if (walk_pos < bwpc_pkg::IE_START)
                              verdict_out.verdict = bwpc_pkg::VERDICT_MALFORMED;
      else if (!privacy)      verdict_out.verdict = bwpc_pkg::VERDICT_NO_PRIVACY;
      else if (psk_hit)       verdict_out.verdict = bwpc_pkg::VERDICT_WPA_PSK;
      else                    verdict_out.verdict = bwpc_pkg::VERDICT_NO_PSK;
      if (verdict_out.verdict inside {bwpc_pkg::VERDICT_MALFORMED, bwpc_pkg::VERDICT_NO_PSK,
                                      bwpc_pkg::VERDICT_WPA_PSK})
         verdict_out.ssid_length = ssid_len;
      expected_verdicts.push_back(verdict_out);
      clear_walk();
   endfunction

   // ------------------------------------------------------------ frame build

   function automatic void put_header(logic [7:0] fc0, bit privacy_on);
      logic [7:0] cap;
      frame_buf.push_back(fc0);
      for (int i = 1; i < bwpc_pkg::CAP_LOW; i++) frame_buf.push_back(8'($urandom));
      cap = 8'($urandom);
      cap = privacy_on ? (cap | PRIVACY_MASK) : (cap & ~PRIVACY_MASK);
      frame_buf.push_back(cap);
      frame_buf.push_back(8'($urandom));
   endfunction

   function automatic void put_ssid(int len, bit hidden);
      frame_buf.push_back(bwpc_pkg::ID_SSID);
      frame_buf.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
         if (hidden) frame_buf.push_back(8'h00);
         else if (i == 0) frame_buf.push_back(8'($urandom_range(1, 255)));
         else frame_buf.push_back(8'($urandom));
      end
   endfunction

   function automatic logic [15:0] overstate(int n);
      return $urandom_range(1) ? 16'(n + 1) : 16'($urandom_range(n + 1, 65535));
   endfunction

   // RSN element or WPA vendor element, PSK suite at akm slot psk_at
   function automatic void put_akm_ie(bit is_rsn, int nc, int na, int psk_at,
                                      ie_flaw_type flaw);
      logic [7:0]  body[$];
      logic [31:0] psk;
      logic [15:0] count;
      int          keep;
      psk = is_rsn ? rsn_suite : wpa_suite;
      if (!is_rsn) begin
         body.push_back(bwpc_pkg::WPA_VENDOR_TAG[31:24]);
         body.push_back(bwpc_pkg::WPA_VENDOR_TAG[23:16]);
         body.push_back(bwpc_pkg::WPA_VENDOR_TAG[15:8]);
         body.push_back(flaw == FLAW_OUI ? 8'($urandom_range(2, 255))
                                         : bwpc_pkg::WPA_VENDOR_TAG[7:0]);
      end
      body.push_back(flaw == FLAW_VERSION ? 8'($urandom_range(2, 255))
                                          : bwpc_pkg::RSN_VERSION1[15:8]);
      body.push_back(bwpc_pkg::RSN_VERSION1[7:0]);
      repeat (4) body.push_back(8'($urandom));
      count = (flaw == FLAW_CIPHER_COUNT) ? overstate(nc) : 16'(nc);
      body.push_back(count[7:0]);
      body.push_back(count[15:8]);
      repeat (4 * nc) body.push_back(8'($urandom));
      count = (flaw == FLAW_AKM_COUNT) ? overstate(na) : 16'(na);
      body.push_back(count[7:0]);
      body.push_back(count[15:8]);
      for (int i = 0; i < na; i++) begin
         for (int j = 3; j >= 0; j--)
            body.push_back(i == psk_at ? psk[8*j +: 8] : 8'($urandom));
      end
      // trailing capability bytes
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
      if (flaw == FLAW_SHORT_BODY) begin
         keep = $urandom_range(0, is_rsn ? 7 : 11);
         while (body.size() > keep) void'(body.pop_back());
      end
      frame_buf.push_back(is_rsn ? bwpc_pkg::ID_RSN : bwpc_pkg::ID_VENDOR);
      frame_buf.push_back(8'(body.size()));
      foreach (body[i]) frame_buf.push_back(body[i]);
   endfunction

   function automatic void put_other_ie();
      logic [7:0] id;
      int         len;
      id  = 8'($urandom);
      if (id inside {bwpc_pkg::ID_SSID, bwpc_pkg::ID_RSN, bwpc_pkg::ID_VENDOR}) id = ID_FILLER;
      len = $urandom_range(0, 24);
      frame_buf.push_back(id);
      frame_buf.push_back(8'(len));
      repeat (len) frame_buf.push_back(8'($urandom));
   endfunction

   function automatic void cut_to(int n);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
   endfunction

   // Hand the built frame to the driver, last marker on the final byte
   function automatic void send_frame();
      frame_word_type w;
      foreach (frame_buf[i]) begin
         w.data = frame_buf[i];
         w.last = (i == frame_buf.size() - 1);
         pending_bytes.push_back(w);
      end
      frame_buf.delete();
   endfunction

   function automatic void random_beacon();
      logic [7:0]  fc0;
      ie_flaw_type flaw;
      int          nc;
      int          na;
      fc0 = ($urandom_range(9) == 0) ? 8'($urandom)
                                     : (bwpc_pkg::FC_BEACON | 8'($urandom_range(3)));
      put_header(fc0, $urandom_range(9) != 0);
      if ($urandom_range(4) != 0) put_ssid($urandom_range(0, 32), $urandom_range(5) == 0);
      repeat ($urandom_range(0, 3)) begin
         nc   = $urandom_range(0, 3);
         na   = $urandom_range(0, 3);
         flaw = ($urandom_range(3) == 0) ?
                ie_flaw_type'($urandom_range(FLAW_VERSION, FLAW_OUI)) : FLAW_NONE;
         case ($urandom_range(5))
            0, 1:    put_akm_ie(1'b1, nc, na, $urandom_range(0, 4), flaw);
            2, 3:    put_akm_ie(1'b0, nc, na, $urandom_range(0, 4), flaw);
            4:       put_other_ie();
            default: put_ssid($urandom_range(0, 40), $urandom_range(3) == 0);
         endcase
      end
   endfunction

   function automatic void random_frames(int min_bytes, int min_count);
      int sent_bytes = 0;
      int sent = 0;
      int pick;
      while (sent_bytes < min_bytes || sent < min_count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 48)) frame_buf.push_back(8'($urandom));
         end else begin
            random_beacon();
            if (pick < 27) cut_to($urandom_range(1, frame_buf.size()));
         end
         sent_bytes += frame_buf.size();
         sent++;
         send_frame();
      end
   endfunction

   function automatic void directed_frames();
      // lone end marker, then the longest short frame
      frame_buf.push_back(8'hFF);
      send_frame();
      repeat (bwpc_pkg::HDR_LEN - 1) frame_buf.push_back(8'hFF);
      send_frame();
      // header only: data frame, beacon without fixed fields, beacon one byte short of them
      put_header(FC_DATA, 1'b1);
      cut_to(bwpc_pkg::HDR_LEN);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      cut_to(bwpc_pkg::HDR_LEN);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON | 8'h03, 1'b1);
      cut_to(bwpc_pkg::IE_START - 1);
      send_frame();
      // privacy clear despite a PSK element; privacy set with no elements
      put_header(bwpc_pkg::FC_BEACON, 1'b0);
      put_akm_ie(1'b1, 1, 1, 0, FLAW_NONE);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      send_frame();
      // full SSID and RSN PSK in the last AKM slot
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_ssid(32, 1'b0);
      put_akm_ie(1'b1, 2, 3, 2, FLAW_NONE);
      send_frame();
      // hidden SSID, later SSID ignored, WPA PSK
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_ssid(9, 1'b1);
      put_ssid(5, 1'b0);
      put_akm_ie(1'b0, 1, 1, 0, FLAW_NONE);
      send_frame();
      // empty SSID, a later SSID, vendor element of another type
      put_header(bwpc_pkg::FC_BEACON | 8'h01, 1'b1);
      put_ssid(0, 1'b0);
      put_ssid(12, 1'b0);
      put_akm_ie(1'b0, 1, 1, 0, FLAW_OUI);
      send_frame();
      // damaged RSN elements, an RSN element with no AKM suites, a short WPA element
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_akm_ie(1'b1, 1, 1, 0, FLAW_VERSION);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_akm_ie(1'b1, 1, 1, 0, FLAW_SHORT_BODY);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_akm_ie(1'b1, 1, 1, 0, FLAW_CIPHER_COUNT);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_akm_ie(1'b1, 0, 2, 1, FLAW_AKM_COUNT);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_akm_ie(1'b1, 1, 0, 0, FLAW_NONE);
      send_frame();
      put_header(bwpc_pkg::FC_BEACON, 1'b1);
      put_akm_ie(1'b0, 1, 1, 0, FLAW_SHORT_BODY);
      send_frame();
      // end on an id byte, just after a length byte, and one byte into a body
      for (int n = 1; n <= 3; n++) begin
         put_header(bwpc_pkg::FC_BEACON, 1'b1);
         put_ssid(8, 1'b0);
         cut_to(bwpc_pkg::IE_START + n);
         send_frame();
      end
   endfunction

   // ------------------------------------------------------------- control

   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == bwpc_pkg::CSR_RSN_PSK) rsn_suite = value;
      else wpa_suite = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for the byte queue and every pending verdict to drain
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_verdicts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic void check_field(string field_name, logic [47:0] exp_val,
                                       logic [47:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field_name,
                  exp_val, act_val);
         error_count++;
      end
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      clear_walk();
      rsn_suite = bwpc_pkg::RSN_PSK_RESET;
      wpa_suite = bwpc_pkg::WPA_PSK_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed frames at reset settings, no idling
      directed_frames();
      wait_idle();

      // extreme selectors, sender mostly idle
      write_csr(bwpc_pkg::CSR_RSN_PSK, 32'hFFFF_FFFF);
      write_csr(bwpc_pkg::CSR_WPA_PSK, 32'h0000_0000);
      send_idle_pct = 82;
      random_frames(90, 2);
      wait_idle();

      // random selectors, receiver mostly stalled
      write_csr(bwpc_pkg::CSR_RSN_PSK, $urandom);
      write_csr(bwpc_pkg::CSR_WPA_PSK, $urandom);
      send_idle_pct  = 0;
      recv_stall_pct = 82;
      random_frames(90, 2);
      wait_idle();

      // opposite extremes, light idling on both sides; hold the sender halfway
      write_csr(bwpc_pkg::CSR_RSN_PSK, 32'h0000_0000);
      write_csr(bwpc_pkg::CSR_WPA_PSK, 32'hFFFF_FFFF);
      send_idle_pct  = 9;
      recv_stall_pct = 9;
      random_frames(45, 1);
      wait_idle();
      random_frames(45, 1);
      wait_idle();

      // back to standard selectors, no idling
      write_csr(bwpc_pkg::CSR_RSN_PSK, bwpc_pkg::RSN_PSK_RESET);
      write_csr(bwpc_pkg::CSR_WPA_PSK, bwpc_pkg::WPA_PSK_RESET);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_frames(60, 1);
      wait_idle();

      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // Drive frame bytes; predict on every accepted word
   always @(posedge clock) begin
      if (req_tvalid && req_tready) classify_byte(req_tdata, req_tlast);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_word.data;
            req_tlast  <= next_word.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the verdict side at random
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each verdict word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: verdict word %h with no frame pending", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("verdict", 48'(want.verdict), 48'(rsp_tdata[2:0]));
            check_field("bssid", want.bssid, rsp_tdata[50:3]);
            check_field("ssid_length", 48'(want.ssid_length), 48'(rsp_tdata[58:51]));
            check_field("padding", 48'd0, 48'(rsp_tdata[63:59]));
         end
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/bwpc_pkg.sv
rtl/bwpc_parser.sv
rtl/beacon_wpa_psk_classifier_core.sv
sim/tb_top.sv
